@@ design/swk_pkg.sv @@
// Shared constants, types and helpers for the sliding window k-th smallest unit.
package swk_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int VALUE_BITS   = 31;
    localparam int IDX_BITS     = 10;
    localparam int CNT_BITS     = 11;
    localparam int RANK_BITS    = 11;
    localparam int REQ_BITS     = 2;

    localparam logic [REQ_BITS-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_LEFT  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_RIGHT = 2'd2;

    localparam logic HEAP_LOWER = 1'b0;
    localparam logic HEAP_UPPER = 1'b1;

    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [IDX_BITS-1:0]   index;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef enum logic [1:0] {
        CONT_REBAL,
        CONT_TO_UPPER,
        CONT_TO_LOWER
    } cont_t;

    typedef enum logic [16:0] {
        ST_IDLE      = 17'b00000000000000001,
        ST_LEFT_FLAG = 17'b00000000000000010,
        ST_LEFT_POS  = 17'b00000000000000100,
        ST_RIGHT_RD  = 17'b00000000000001000,
        ST_RM_START  = 17'b00000000000010000,
        ST_RM_OUT    = 17'b00000000000100000,
        ST_RM_LAST   = 17'b00000000001000000,
        ST_RISE      = 17'b00000000010000000,
        ST_RISE_CMP  = 17'b00000000100000000,
        ST_SINK      = 17'b00000001000000000,
        ST_SINK_L    = 17'b00000010000000000,
        ST_SINK_R    = 17'b00000100000000000,
        ST_PUT       = 17'b00001000000000000,
        ST_DONE      = 17'b00010000000000000,
        ST_REBAL     = 17'b00100000000000000,
        ST_REP       = 17'b01000000000000000,
        ST_REP_RD    = 17'b10000000000000000
    } state_t;

    // true when a belongs above b in the selected heap
    function automatic logic ahead(input logic is_max, input entry_t a, input entry_t b);
        logic res;
        res = is_max ? (a.value > b.value) : (a.value < b.value);
        return res;
    endfunction

endpackage

@@ design/swk_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module swk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/sliding_window_kth_smallest_unit.sv @@
// Top level: value store, two indexed heaps and the sequencer that maintains them.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_req_type s_load_value | in
//  result  | m_valid m_ready m_kth_value m_has_answer m_status | out
//  config  | cfg_wr_en cfg_wr_data (rank_k)          | in
//
// Only the first load enters the heaps; a rejected item goes to the report step.
// A move runs the heap sift loop, rising or sinking one level per pass through the
// registered-read heap RAMs, over one removal or insertion and at most one transfer
// between the heaps.
// A rank write while idle starts a rebalance; s_ready stays low until it ends.
// Reset clears counters and window ends; no RAM clearing pass is needed.
// A result waiting on m_ready holds the sequencer in its report step only.
module sliding_window_kth_smallest_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [swk_pkg::REQ_BITS-1:0]        s_req_type,
    input  logic [swk_pkg::VALUE_BITS-1:0]      s_load_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [swk_pkg::VALUE_BITS-1:0]      m_kth_value,
    output logic                                m_has_answer,
    output logic                                m_status,
    input  logic                                cfg_wr_en,
    input  logic [swk_pkg::RANK_BITS-1:0]       cfg_wr_data
);

    localparam int IW = swk_pkg::IDX_BITS;
    localparam int CW = swk_pkg::CNT_BITS;

    swk_pkg::state_t state_reg, state_next;
    swk_pkg::cont_t  cont_reg, cont_next;
    logic            hsel_reg, hsel_next;
    logic            rep_pend_reg, rep_pend_next;
    logic            status_reg, status_next;
    logic            sink_after_reg, sink_after_next;
    logic [swk_pkg::RANK_BITS-1:0] rank_reg, rank_next;
    logic [CW-1:0]   loaded_reg, loaded_next;
    logic [IW-1:0]   left_reg, left_next;
    logic [IW-1:0]   right_reg, right_next;
    logic [CW-1:0]   lcnt_reg, lcnt_next;
    logic [CW-1:0]   ucnt_reg, ucnt_next;
    logic            m_valid_reg, m_valid_next;

    logic [IW-1:0]   i_reg, i_next;
    logic [IW-1:0]   idx_reg, idx_next;
    swk_pkg::entry_t cur_reg, cur_next;
    swk_pkg::entry_t out_reg, out_next;
    swk_pkg::entry_t child_reg, child_next;
    logic [swk_pkg::VALUE_BITS-1:0] m_value_reg, m_value_next;
    logic            m_has_reg, m_has_next;
    logic            m_status_reg, m_status_next;

    logic                           vs_we;
    logic [IW-1:0]                  vs_waddr, vs_raddr;
    logic [swk_pkg::VALUE_BITS-1:0] vs_wdata, vs_rdata;
    logic                           fl_we, fl_wdata, fl_rdata;
    logic [IW-1:0]                  fl_waddr, fl_raddr;
    logic                           e_we;
    logic [IW-1:0]                  e_waddr, e_raddr;
    swk_pkg::entry_t                e_wdata, e_rdata, lo_rdata, up_rdata;
    logic [IW-1:0]                  p_raddr, p_rdata, lo_prdata, up_prdata;

    logic          is_max;
    logic [CW-1:0] cnt_sel;
    logic [CW-1:0] last;
    logic [IW-1:0] parent;
    logic [CW:0]   lpos, rpos;
    logic          accept;
    logic          reject;
    logic          use_right;
    swk_pkg::entry_t sel_child;
    logic [IW-1:0] sel_pos;

    swk_ram #(.WIDTH(swk_pkg::VALUE_BITS), .DEPTH(swk_pkg::MAX_ELEMENTS)) u_value_ram (
        .aclk(aclk), .we(vs_we), .waddr(vs_waddr), .wdata(vs_wdata),
        .raddr(vs_raddr), .rdata(vs_rdata)
    );

    swk_ram #(.WIDTH(1), .DEPTH(swk_pkg::MAX_ELEMENTS)) u_flag_ram (
        .aclk(aclk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
        .raddr(fl_raddr), .rdata(fl_rdata)
    );

    swk_ram #(.WIDTH(swk_pkg::ENTRY_BITS), .DEPTH(swk_pkg::MAX_ELEMENTS)) u_lo_ent_ram (
        .aclk(aclk), .we(e_we && (hsel_reg == swk_pkg::HEAP_LOWER)), .waddr(e_waddr),
        .wdata(e_wdata), .raddr(e_raddr), .rdata(lo_rdata)
    );

    swk_ram #(.WIDTH(swk_pkg::ENTRY_BITS), .DEPTH(swk_pkg::MAX_ELEMENTS)) u_up_ent_ram (
        .aclk(aclk), .we(e_we && (hsel_reg == swk_pkg::HEAP_UPPER)), .waddr(e_waddr),
        .wdata(e_wdata), .raddr(e_raddr), .rdata(up_rdata)
    );

    swk_ram #(.WIDTH(IW), .DEPTH(swk_pkg::MAX_ELEMENTS)) u_lo_pos_ram (
        .aclk(aclk), .we(e_we && (hsel_reg == swk_pkg::HEAP_LOWER)),
        .waddr(e_wdata.index), .wdata(e_waddr), .raddr(p_raddr), .rdata(lo_prdata)
    );

    swk_ram #(.WIDTH(IW), .DEPTH(swk_pkg::MAX_ELEMENTS)) u_up_pos_ram (
        .aclk(aclk), .we(e_we && (hsel_reg == swk_pkg::HEAP_UPPER)),
        .waddr(e_wdata.index), .wdata(e_waddr), .raddr(p_raddr), .rdata(up_prdata)
    );

    assign e_rdata = (hsel_reg == swk_pkg::HEAP_LOWER) ? lo_rdata : up_rdata;
    assign p_rdata = (hsel_reg == swk_pkg::HEAP_LOWER) ? lo_prdata : up_prdata;
    assign cnt_sel = (hsel_reg == swk_pkg::HEAP_LOWER) ? lcnt_reg : ucnt_reg;
    assign is_max  = (hsel_reg == swk_pkg::HEAP_LOWER);
    assign last    = cnt_sel - CW'(1);
    assign parent  = (i_reg - IW'(1)) >> 1;
    assign lpos    = {1'b0, i_reg, 1'b1};
    assign rpos    = lpos + (CW+1)'(1);

    assign s_ready      = (state_reg == swk_pkg::ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_kth_value  = m_value_reg;
    assign m_has_answer = m_has_reg;
    assign m_status     = m_status_reg;

    // pick the child to compare against the hole in the sink step
    always_comb begin
        use_right = (state_reg == swk_pkg::ST_SINK_R)
                    && !swk_pkg::ahead(is_max, child_reg, e_rdata);
        sel_child = use_right ? e_rdata : ((state_reg == swk_pkg::ST_SINK_R) ? child_reg : e_rdata);
        sel_pos   = use_right ? rpos[IW-1:0] : lpos[IW-1:0];
    end

    always_comb begin
        state_next      = state_reg;
        cont_next       = cont_reg;
        hsel_next       = hsel_reg;
        rep_pend_next   = rep_pend_reg;
        status_next     = status_reg;
        sink_after_next = sink_after_reg;
        rank_next       = cfg_wr_en ? cfg_wr_data : rank_reg;
        loaded_next     = loaded_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        lcnt_next       = lcnt_reg;
        ucnt_next       = ucnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        i_next          = i_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        out_next        = out_reg;
        child_next      = child_reg;
        m_value_next    = m_value_reg;
        m_has_next      = m_has_reg;
        m_status_next   = m_status_reg;
        reject          = 1'b0;

        vs_we    = 1'b0;
        vs_waddr = loaded_reg[IW-1:0];
        vs_wdata = s_load_value;
        vs_raddr = right_reg + IW'(1);
        fl_we    = 1'b0;
        fl_waddr = left_reg;
        fl_wdata = 1'b0;
        fl_raddr = left_reg;
        e_we     = 1'b0;
        e_waddr  = i_reg;
        e_wdata  = cur_reg;
        e_raddr  = '0;
        p_raddr  = idx_reg;

        case (state_reg)
            swk_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_req_type)
                        swk_pkg::REQ_LOAD: begin
                            if (loaded_reg == CW'(swk_pkg::MAX_ELEMENTS)) begin
                                reject = 1'b1;
                            end else begin
                                vs_we       = 1'b1;
                                fl_we       = 1'b1;
                                fl_waddr    = loaded_reg[IW-1:0];
                                fl_wdata    = (loaded_reg == '0);
                                loaded_next = loaded_reg + CW'(1);
                                if (loaded_reg == '0) begin
                                    cur_next        = '{value: s_load_value, index: '0};
                                    hsel_next       = swk_pkg::HEAP_LOWER;
                                    i_next          = lcnt_reg[IW-1:0];
                                    lcnt_next       = lcnt_reg + CW'(1);
                                    sink_after_next = 1'b0;
                                    cont_next       = swk_pkg::CONT_REBAL;
                                    rep_pend_next   = 1'b0;
                                    state_next      = swk_pkg::ST_RISE;
                                end
                            end
                        end
                        swk_pkg::REQ_LEFT: begin
                            if (loaded_reg == '0 || left_reg >= right_reg) begin
                                reject = 1'b1;
                            end else begin
                                idx_next      = left_reg;
                                left_next     = left_reg + IW'(1);
                                status_next   = swk_pkg::STATUS_DONE;
                                rep_pend_next = 1'b1;
                                state_next    = swk_pkg::ST_LEFT_FLAG;
                            end
                        end
                        swk_pkg::REQ_RIGHT: begin
                            if (loaded_reg == '0
                                || ({1'b0, right_reg} + CW'(1)) >= loaded_reg) begin
                                reject = 1'b1;
                            end else begin
                                right_next    = right_reg + IW'(1);
                                status_next   = swk_pkg::STATUS_DONE;
                                rep_pend_next = 1'b1;
                                state_next    = swk_pkg::ST_RIGHT_RD;
                            end
                        end
                        default: begin
                            reject = 1'b1;
                        end
                    endcase
                    if (reject) begin
                        status_next   = swk_pkg::STATUS_REJECTED;
                        rep_pend_next = 1'b1;
                        state_next    = swk_pkg::ST_REP;
                    end
                end else if (cfg_wr_en) begin
                    rep_pend_next = 1'b0;
                    state_next    = swk_pkg::ST_REBAL;
                end
            end
            swk_pkg::ST_LEFT_FLAG: begin
                hsel_next  = fl_rdata ? swk_pkg::HEAP_LOWER : swk_pkg::HEAP_UPPER;
                state_next = swk_pkg::ST_LEFT_POS;
            end
            swk_pkg::ST_LEFT_POS: begin
                i_next     = p_rdata;
                cont_next  = swk_pkg::CONT_REBAL;
                state_next = swk_pkg::ST_RM_START;
            end
            swk_pkg::ST_RIGHT_RD: begin
                cur_next        = '{value: vs_rdata, index: right_reg};
                fl_we           = 1'b1;
                fl_waddr        = right_reg;
                fl_wdata        = 1'b1;
                hsel_next       = swk_pkg::HEAP_LOWER;
                i_next          = lcnt_reg[IW-1:0];
                lcnt_next       = lcnt_reg + CW'(1);
                sink_after_next = 1'b0;
                cont_next       = swk_pkg::CONT_REBAL;
                state_next      = swk_pkg::ST_RISE;
            end
            swk_pkg::ST_RM_START: begin
                e_raddr    = i_reg;
                state_next = swk_pkg::ST_RM_OUT;
            end
            swk_pkg::ST_RM_OUT: begin
                out_next   = e_rdata;
                e_raddr    = last[IW-1:0];
                state_next = swk_pkg::ST_RM_LAST;
            end
            swk_pkg::ST_RM_LAST: begin
                cur_next = e_rdata;
                if (hsel_reg == swk_pkg::HEAP_LOWER) begin
                    lcnt_next = last;
                end else begin
                    ucnt_next = last;
                end
                if ({1'b0, i_reg} == last) begin
                    state_next = swk_pkg::ST_DONE;
                end else begin
                    sink_after_next = 1'b1;
                    state_next      = swk_pkg::ST_RISE;
                end
            end
            swk_pkg::ST_RISE: begin
                if (i_reg == '0) begin
                    state_next = sink_after_reg ? swk_pkg::ST_SINK : swk_pkg::ST_PUT;
                end else begin
                    e_raddr    = parent;
                    state_next = swk_pkg::ST_RISE_CMP;
                end
            end
            swk_pkg::ST_RISE_CMP: begin
                if (swk_pkg::ahead(is_max, cur_reg, e_rdata)) begin
                    e_we            = 1'b1;
                    e_wdata         = e_rdata;
                    i_next          = parent;
                    sink_after_next = 1'b0;
                    state_next      = swk_pkg::ST_RISE;
                end else begin
                    state_next = sink_after_reg ? swk_pkg::ST_SINK : swk_pkg::ST_PUT;
                end
            end
            swk_pkg::ST_SINK: begin
                if (lpos >= {1'b0, cnt_sel}) begin
                    state_next = swk_pkg::ST_PUT;
                end else begin
                    e_raddr    = lpos[IW-1:0];
                    state_next = swk_pkg::ST_SINK_L;
                end
            end
            swk_pkg::ST_SINK_L, swk_pkg::ST_SINK_R: begin
                if (state_reg == swk_pkg::ST_SINK_L && rpos < {1'b0, cnt_sel}) begin
                    child_next = e_rdata;
                    e_raddr    = rpos[IW-1:0];
                    state_next = swk_pkg::ST_SINK_R;
                end else if (swk_pkg::ahead(is_max, sel_child, cur_reg)) begin
                    e_we       = 1'b1;
                    e_wdata    = sel_child;
                    i_next     = sel_pos;
                    state_next = swk_pkg::ST_SINK;
                end else begin
                    state_next = swk_pkg::ST_PUT;
                end
            end
            swk_pkg::ST_PUT: begin
                e_we       = 1'b1;
                state_next = swk_pkg::ST_DONE;
            end
            swk_pkg::ST_DONE: begin
                case (cont_reg)
                    swk_pkg::CONT_TO_UPPER, swk_pkg::CONT_TO_LOWER: begin
                        fl_we           = 1'b1;
                        fl_waddr        = out_reg.index;
                        fl_wdata        = (cont_reg == swk_pkg::CONT_TO_LOWER);
                        cur_next        = out_reg;
                        sink_after_next = 1'b0;
                        cont_next       = swk_pkg::CONT_REBAL;
                        state_next      = swk_pkg::ST_RISE;
                        if (cont_reg == swk_pkg::CONT_TO_UPPER) begin
                            hsel_next = swk_pkg::HEAP_UPPER;
                            i_next    = ucnt_reg[IW-1:0];
                            ucnt_next = ucnt_reg + CW'(1);
                        end else begin
                            hsel_next = swk_pkg::HEAP_LOWER;
                            i_next    = lcnt_reg[IW-1:0];
                            lcnt_next = lcnt_reg + CW'(1);
                        end
                    end
                    default: begin
                        state_next = swk_pkg::ST_REBAL;
                    end
                endcase
            end
            swk_pkg::ST_REBAL: begin
                if (lcnt_reg > rank_reg) begin
                    hsel_next  = swk_pkg::HEAP_LOWER;
                    i_next     = '0;
                    cont_next  = swk_pkg::CONT_TO_UPPER;
                    state_next = swk_pkg::ST_RM_START;
                end else if (lcnt_reg < rank_reg && ucnt_reg != '0) begin
                    hsel_next  = swk_pkg::HEAP_UPPER;
                    i_next     = '0;
                    cont_next  = swk_pkg::CONT_TO_LOWER;
                    state_next = swk_pkg::ST_RM_START;
                end else begin
                    state_next = rep_pend_reg ? swk_pkg::ST_REP : swk_pkg::ST_IDLE;
                end
            end
            swk_pkg::ST_REP: begin
                state_next = swk_pkg::ST_REP_RD;
            end
            swk_pkg::ST_REP_RD: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_has_next    = (rank_reg != '0) && (lcnt_reg == rank_reg);
                    m_value_next  = m_has_next ? lo_rdata.value : '0;
                    m_status_next = status_reg;
                    state_next    = swk_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swk_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= swk_pkg::ST_IDLE;
            cont_reg       <= swk_pkg::CONT_REBAL;
            hsel_reg       <= swk_pkg::HEAP_LOWER;
            rep_pend_reg   <= 1'b0;
            status_reg     <= swk_pkg::STATUS_DONE;
            sink_after_reg <= 1'b0;
            rank_reg       <= swk_pkg::RANK_BITS'(1);
            loaded_reg     <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            lcnt_reg       <= '0;
            ucnt_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cont_reg       <= cont_next;
            hsel_reg       <= hsel_next;
            rep_pend_reg   <= rep_pend_next;
            status_reg     <= status_next;
            sink_after_reg <= sink_after_next;
            rank_reg       <= rank_next;
            loaded_reg     <= loaded_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            lcnt_reg       <= lcnt_next;
            ucnt_reg       <= ucnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        idx_reg      <= idx_next;
        cur_reg      <= cur_next;
        out_reg      <= out_next;
        child_reg    <= child_next;
        m_value_reg  <= m_value_next;
        m_has_reg    <= m_has_next;
        m_status_reg <= m_status_next;
    end

endmodule

@@ dv/tb_sliding_window_kth_smallest_unit.sv @@
// Testbench for the sliding window k-th smallest unit: directed and random items, checked.
module tb_sliding_window_kth_smallest_unit;

    localparam logic [swk_pkg::REQ_BITS-1:0] REQ_UNKNOWN = 2'd3;
    localparam int QUIET_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct {
        logic [swk_pkg::VALUE_BITS-1:0] kth;
        logic                           has;
        logic                           status;
    } answer_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [swk_pkg::REQ_BITS-1:0]   s_req_type = swk_pkg::REQ_LOAD;
    logic [swk_pkg::VALUE_BITS-1:0] s_load_value = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [swk_pkg::VALUE_BITS-1:0] m_kth_value;
    logic                           m_has_answer;
    logic                           m_status;
    logic                           cfg_wr_en = 1'b0;
    logic [swk_pkg::RANK_BITS-1:0]  cfg_wr_data = '0;

    // window tracking
    logic [swk_pkg::VALUE_BITS-1:0] array_vals [swk_pkg::MAX_ELEMENTS];
    int unsigned           n_loaded = 0;
    int unsigned           win_lo = 0;
    int unsigned           win_hi = 0;
    int unsigned           cur_rank = 1;

    answer_t               pending_answers [$];
    bit                    no_idle = 1'b0;
    int                    ready_hold = 0;
    int                    errors = 0;
    int                    n_results = 0;
    int                    n_rejected = 0;
    int                    n_answered = 0;
    int                    quiet_cycles = 0;

    always #6 aclk = ~aclk;

    sliding_window_kth_smallest_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_load_value(s_load_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_kth_value(m_kth_value), .m_has_answer(m_has_answer), .m_status(m_status),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    function automatic answer_t window_answer(logic status);
        answer_t a;
        logic [swk_pkg::VALUE_BITS-1:0] sorted [$];
        int unsigned size;
        size = (n_loaded == 0) ? 0 : win_hi - win_lo + 1;
        a.status = status;
        a.has = (cur_rank >= 1) && (size >= cur_rank);
        a.kth = '0;
        if (a.has) begin
            for (int unsigned i = win_lo; i <= win_hi; i++) sorted.push_back(array_vals[i]);
            sorted.sort();
            a.kth = sorted[cur_rank-1];
        end
        return a;
    endfunction

    function automatic void track_item(logic [swk_pkg::REQ_BITS-1:0] req,
                                       logic [swk_pkg::VALUE_BITS-1:0] val);
        case (req)
            swk_pkg::REQ_LOAD: begin
                if (n_loaded >= swk_pkg::MAX_ELEMENTS) begin
                    pending_answers.push_back(window_answer(swk_pkg::STATUS_REJECTED));
                end else begin
                    array_vals[n_loaded] = val;
                    n_loaded++;
                end
            end
            swk_pkg::REQ_LEFT: begin
                if (n_loaded == 0 || win_lo >= win_hi) begin
                    pending_answers.push_back(window_answer(swk_pkg::STATUS_REJECTED));
                end else begin
                    win_lo++;
                    pending_answers.push_back(window_answer(swk_pkg::STATUS_DONE));
                end
            end
            swk_pkg::REQ_RIGHT: begin
                if (n_loaded == 0 || win_hi + 1 >= n_loaded) begin
                    pending_answers.push_back(window_answer(swk_pkg::STATUS_REJECTED));
                end else begin
                    win_hi++;
                    pending_answers.push_back(window_answer(swk_pkg::STATUS_DONE));
                end
            end
            default: pending_answers.push_back(window_answer(swk_pkg::STATUS_REJECTED));
        endcase
    endfunction

    task automatic send_item(logic [swk_pkg::REQ_BITS-1:0] req,
                             logic [swk_pkg::VALUE_BITS-1:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_load_value <= val;
        do @(posedge aclk); while (!s_ready);
        track_item(req, val);
    endtask

    task automatic write_rank(int unsigned rank);
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= rank[swk_pkg::RANK_BITS-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_rank = rank;
    endtask

    function automatic logic [swk_pkg::VALUE_BITS-1:0] random_value();
        case ($urandom_range(0, 3))
            0: return swk_pkg::VALUE_BITS'($urandom_range(0, 15));
            1: return {swk_pkg::VALUE_BITS{1'b1}} - swk_pkg::VALUE_BITS'($urandom_range(0, 3));
            default: return swk_pkg::VALUE_BITS'($urandom);
        endcase
    endfunction

    // checker and receiver stalls
    always @(posedge aclk) begin
        answer_t e;
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[sliding_window_kth_smallest_unit] ERROR");
            $finish;
        end
        if (m_valid && m_ready) begin
            ready_hold = no_idle ? 0 : $urandom_range(0, 9);
            if (pending_answers.size() == 0) begin
                $error("unexpected result kth_value=%0d has_answer=%0b status=%0b",
                       m_kth_value, m_has_answer, m_status);
                errors++;
            end else begin
                e = pending_answers.pop_front();
                n_results++;
                if (e.status) n_rejected++;
                if (e.has) n_answered++;
                if (m_kth_value !== e.kth) begin
                    $error("kth_value expected %0d actual %0d", e.kth, m_kth_value);
                    errors++;
                end
                if (m_has_answer !== e.has) begin
                    $error("has_answer expected %0b actual %0b", e.has, m_has_answer);
                    errors++;
                end
                if (m_status !== e.status) begin
                    $error("status expected %0b actual %0b", e.status, m_status);
                    errors++;
                end
            end
        end else if (ready_hold > 0) begin
            ready_hold--;
        end
    end

    always @(negedge aclk) m_ready <= aresetn && (ready_hold == 0);

    task automatic test_empty_block();
        send_item(swk_pkg::REQ_LEFT, random_value());
        send_item(swk_pkg::REQ_RIGHT, random_value());
        send_item(REQ_UNKNOWN, random_value());
    endtask

    task automatic test_directed_moves();
        send_item(swk_pkg::REQ_LOAD, {swk_pkg::VALUE_BITS{1'b1}});
        send_item(swk_pkg::REQ_LOAD, '0);
        send_item(swk_pkg::REQ_LOAD, 31'd5);
        send_item(swk_pkg::REQ_LOAD, 31'd5);
        send_item(swk_pkg::REQ_LOAD, 31'h2AAAAAAA);
        send_item(swk_pkg::REQ_LOAD, 31'h55555555);
        send_item(swk_pkg::REQ_LEFT, '0);
        send_item(swk_pkg::REQ_RIGHT, '0);
        send_item(swk_pkg::REQ_RIGHT, '0);
        send_item(swk_pkg::REQ_RIGHT, '0);
        send_item(swk_pkg::REQ_LEFT, '0);
        send_item(swk_pkg::REQ_RIGHT, '0);
        send_item(swk_pkg::REQ_RIGHT, '0);
        send_item(swk_pkg::REQ_RIGHT, '0);
        send_item(REQ_UNKNOWN, {swk_pkg::VALUE_BITS{1'b1}});
    endtask

    task automatic test_rank_changes();
        write_rank(3);
        send_item(swk_pkg::REQ_LEFT, '0);
        write_rank(0);
        send_item(swk_pkg::REQ_LEFT, '0);
        write_rank(2047);
        send_item(swk_pkg::REQ_LOAD, 31'd7);
        send_item(swk_pkg::REQ_RIGHT, '0);
        write_rank(1024);
        send_item(swk_pkg::REQ_LEFT, '0);
        write_rank(2);
        send_item(swk_pkg::REQ_LEFT, '0);
        send_item(swk_pkg::REQ_LEFT, '0);
    endtask

    task automatic test_random_windows();
        int unsigned ranks [8] = '{1, 2, 4, 0, 7, 1, 3, 12};
        int unsigned target;
        int unsigned size;
        for (int ph = 0; ph < 8; ph++) begin
            write_rank(ph == 7 ? $urandom_range(1, 16) : ranks[ph]);
            no_idle = (ph % 3 == 2);
            target = $urandom_range(1, 24);
            for (int i = 0; i < 150; i++) begin
                size = win_hi - win_lo + 1;
                if ($urandom_range(0, 99) < 4)
                    send_item(REQ_UNKNOWN, random_value());
                else if (n_loaded < swk_pkg::MAX_ELEMENTS && $urandom_range(0, 99) < 55)
                    send_item(swk_pkg::REQ_LOAD, random_value());
                else if ($urandom_range(0, 99) < (size < target ? 80 : 25))
                    send_item(swk_pkg::REQ_RIGHT, random_value());
                else
                    send_item(swk_pkg::REQ_LEFT, random_value());
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_full_store();
        while (n_loaded < swk_pkg::MAX_ELEMENTS) send_item(swk_pkg::REQ_LOAD, random_value());
        repeat (3) send_item(swk_pkg::REQ_LOAD, random_value());
        repeat (4) send_item(swk_pkg::REQ_RIGHT, '0);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_block();
        test_directed_moves();
        test_rank_changes();
        test_random_windows();
        test_full_store();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("checked %0d results: %0d rejected, %0d with an answer", n_results,
                 n_rejected, n_answered);
        $display("loaded %0d values, final window [%0d,%0d], final rank %0d", n_loaded,
                 win_lo, win_hi, cur_rank);
        if (errors == 0 && pending_answers.size() == 0)
            $display("[sliding_window_kth_smallest_unit] OK");
        else
            $display("[sliding_window_kth_smallest_unit] ERROR");
        $finish;
    end

endmodule
